FILE: rtl/core/rational_arith_reduce_top_macros.svh
// Assertion macros for the rational arithmetic block.
// Used by rational_arith_reduce_top; expects clk and rst in scope.
`ifndef RATIONAL_ARITH_REDUCE_TOP_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_TOP_MACROS_SVH

// same-cycle implication
`define RAR_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rar check failed");

// next-cycle implication
`define RAR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rar check failed");

`endif

FILE: rtl/core/rar_pkg.sv
// Package for the rational arithmetic block: widths, op codes, sequencer states.
// No dependencies.
`default_nettype none
package rar_pkg;
  localparam int DEF_IN_WIDTH = 16;
  localparam int NUM_W = 33;
  localparam int DEN_W = 31;
  localparam int OUT_TW = 64;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} rar_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_SUM, ST_GCD, ST_DIVN, ST_DIVD, ST_DONE
  } rar_state_t;
endpackage
`default_nettype wire

FILE: rtl/core/rar_gcd.sv
// Binary gcd unit: one shift or subtract per cycle.
// Standalone; used by rational_arith_reduce_top.
`default_nettype none
module rar_gcd #(
  parameter int PW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [PW-1:0] a_in,
  input  wire logic [PW-1:0] b_in,
  output logic               done,
  output logic [PW-1:0]      g
);
  localparam int KW = $clog2(PW + 1);

  logic          busy;
  logic [PW-1:0] a;
  logic [PW-1:0] b;
  logic [KW-1:0] k;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a    <= a_in;
        b    <= b_in;
        k    <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (a == '0) begin
          g    <= b << k;
          busy <= 1'b0;
          done <= 1'b1;
        end else if (b == '0) begin
          g    <= a << k;
          busy <= 1'b0;
          done <= 1'b1;
        end else if (!a[0] && !b[0]) begin
          a <= a >> 1;
          b <= b >> 1;
          k <= k + 1'b1;
        end else if (!a[0]) begin
          a <= a >> 1;
        end else if (!b[0]) begin
          b <= b >> 1;
        end else if (a >= b) begin
          a <= a - b;
        end else begin
          b <= b - a;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/rar_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Standalone; used by rational_arith_reduce_top.
`default_nettype none
module rar_div #(
  parameter int PW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [PW-1:0] dividend,
  input  wire logic [PW-1:0] divisor,
  output logic               done,
  output logic [PW-1:0]      quot
);
  localparam int CW = $clog2(PW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [PW-1:0] rem;
  logic [PW-1:0] dv;
  logic [PW:0]   rs;
  logic [PW:0]   rd;
  logic          ge;

  always_comb begin
    rs = {rem, quot[PW-1]};
    ge = rs >= {1'b0, dv};
    rd = ge ? rs - {1'b0, dv} : rs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quot <= dividend;
        dv   <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= rd[PW-1:0];
        quot <= {quot[PW-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(PW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/rational_arith_reduce_top.sv
// Rational add/subtract/multiply/divide with reduction to lowest terms.
// Depends on rar_pkg, rar_gcd, rar_div and rational_arith_reduce_top_macros.svh.
//
// One item at a time: the shared multiplier forms the products in ST_MUL1,
// ST_MUL2 and ST_MUL3, ST_SUM forms the signed sum, a binary gcd runs at one
// shift or subtract a cycle, then two exact divisions run on the serial
// divider and the result is loaded into the output register. A zero result
// skips the gcd and the divisions; an item with a zero denominator or a divide
// by zero goes straight to ST_DONE. No new item is taken until the
// previous result is in the output register.
`default_nettype none
`include "rational_arith_reduce_top_macros.svh"
module rational_arith_reduce_top #(
  parameter int IN_WIDTH = rar_pkg::DEF_IN_WIDTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // op, num_a, den_a, num_b, den_b
  input  wire logic [((2 + 4 * IN_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // res_num, res_den
  output logic [rar_pkg::OUT_TW-1:0] m_axis_tdata,
  // error
  output logic      m_axis_tuser
);
  import rar_pkg::*;

  localparam int W  = IN_WIDTH;
  localparam int PW = 2 * IN_WIDTH;
  localparam int XN = (PW + 1 > NUM_W) ? PW + 1 : NUM_W;
  localparam int XD = (PW > DEN_W) ? PW : DEN_W;

  rar_state_t state, state_next;

  logic         s_acc;
  rar_op_t      in_op;
  logic [W-1:0] in_na, in_da, in_nb, in_db;
  logic         in_err;

  rar_op_t      op;
  logic         na_neg, da_neg, nb_neg, db_neg;
  logic [W-1:0] mna, mda, mnb, mdb;
  logic [W-1:0] mul_a, mul_b;
  logic [PW-1:0] prod;
  logic [PW-1:0] p1, p2, p3;
  logic         s1, s2, s3;
  logic [PW-1:0] sum_mag;
  logic         sum_neg;
  logic [PW-1:0] nmag;
  logic         rneg;
  logic         zres, err;
  logic [PW-1:0] qn, qd;

  logic          gcd_start, gcd_done;
  logic [PW-1:0] gcd_g;
  logic          div_start, div_done;
  logic [PW-1:0] div_dividend, div_q;

  logic [XN-1:0] num_x;
  logic [XD-1:0] den_x;
  logic [NUM_W-1:0] out_num;
  logic [DEN_W-1:0] out_den;
  logic             load_out;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_op  = rar_op_t'(s_axis_tdata[1:0]);
    in_na  = s_axis_tdata[2 +: W];
    in_da  = s_axis_tdata[2 + W +: W];
    in_nb  = s_axis_tdata[2 + 2 * W +: W];
    in_db  = s_axis_tdata[2 + 3 * W +: W];
    in_err = (in_da == '0) || (in_db == '0) || ((in_op == OP_DIV) && (in_nb == '0));
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      op     <= in_op;
      na_neg <= in_na[W-1];
      da_neg <= in_da[W-1];
      nb_neg <= in_nb[W-1];
      db_neg <= in_db[W-1];
      mna    <= in_na[W-1] ? -in_na : in_na;
      mda    <= in_da[W-1] ? -in_da : in_da;
      mnb    <= in_nb[W-1] ? -in_nb : in_nb;
      mdb    <= in_db[W-1] ? -in_db : in_db;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = mna;
    mul_b = mdb;
    unique case (state)
      ST_MUL1: begin
        mul_a = mna;
        mul_b = (op == OP_MUL) ? mnb : mdb;
      end
      ST_MUL2: begin
        mul_a = mnb;
        mul_b = mda;
      end
      ST_MUL3: begin
        mul_a = mda;
        mul_b = (op == OP_DIV) ? mnb : mdb;
      end
      default: begin
        mul_a = mna;
        mul_b = mdb;
      end
    endcase
    prod = PW'(mul_a) * PW'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL1) p1 <= prod;
    if (state == ST_MUL2) p2 <= prod;
    if (state == ST_MUL3) p3 <= prod;
  end

  always_comb begin
    s1 = (op == OP_MUL) ? (na_neg ^ nb_neg) : (na_neg ^ db_neg);
    s2 = nb_neg ^ da_neg ^ (op == OP_SUB);
    s3 = (op == OP_DIV) ? (da_neg ^ nb_neg) : (da_neg ^ db_neg);
    if (op == OP_MUL || op == OP_DIV) begin
      sum_mag = p1;
      sum_neg = s1;
    end else if (s1 == s2) begin
      sum_mag = p1 + p2;
      sum_neg = s1;
    end else if (p1 >= p2) begin
      sum_mag = p1 - p2;
      sum_neg = s1;
    end else begin
      sum_mag = p2 - p1;
      sum_neg = s2;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      err  <= in_err;
      zres <= in_err;
    end
    if (state == ST_SUM) begin
      nmag <= sum_mag;
      rneg <= sum_neg ^ s3;
      zres <= (sum_mag == '0);
    end
    if (state == ST_DIVN && div_done) qn <= div_q;
    if (state == ST_DIVD && div_done) qd <= div_q;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next   = state;
    gcd_start    = 1'b0;
    div_start    = 1'b0;
    div_dividend = (state == ST_GCD) ? nmag : p3;
    load_out     = 1'b0;
    unique case (state)
      ST_IDLE: if (s_acc) state_next = in_err ? ST_DONE : ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_SUM;
      ST_SUM: begin
        if (sum_mag == '0) begin
          state_next = ST_DONE;
        end else begin
          gcd_start  = 1'b1;
          state_next = ST_GCD;
        end
      end
      ST_GCD: begin
        if (gcd_done) begin
          div_start  = 1'b1;
          state_next = ST_DIVN;
        end
      end
      ST_DIVN: begin
        if (div_done) begin
          div_start  = 1'b1;
          state_next = ST_DIVD;
        end
      end
      ST_DIVD: if (div_done) state_next = ST_DONE;
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  rar_gcd #(.PW(PW)) u_gcd (
    .clk  (clk),
    .rst  (rst),
    .start(gcd_start),
    .a_in (sum_mag),
    .b_in (p3),
    .done (gcd_done),
    .g    (gcd_g)
  );

  rar_div #(.PW(PW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (gcd_g),
    .done    (div_done),
    .quot    (div_q)
  );

  always_comb begin
    num_x   = rneg ? -XN'(qn) : XN'(qn);
    den_x   = XD'(qd);
    out_num = zres ? '0 : num_x[NUM_W-1:0];
    out_den = zres ? DEN_W'(1) : den_x[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= OUT_TW'({out_den, out_num});
      m_axis_tuser <= err;
    end
  end

  `RAR_ASSERT_NEXT(a_err_fast, s_acc && in_err, state == ST_DONE)
  `RAR_ASSERT_IMPLY(a_gcd_nz, gcd_done, gcd_g != '0)
  `RAR_ASSERT_IMPLY(a_den_nz, m_axis_tvalid, m_axis_tdata[NUM_W +: DEN_W] != '0)
  `RAR_ASSERT_IMPLY(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata[NUM_W-1:0] == '0)
endmodule
`default_nettype wire

FILE: verif/rational_arith_reduce_top_tb.sv
// Testbench for rational_arith_reduce_top: fraction add/sub/mul/div with reduction.
// Self-checking against an in-bench predictor; depends on rar_pkg and the RTL.
`default_nettype none
module rational_arith_reduce_top_tb;
  import rar_pkg::*;

  localparam int IW = DEF_IN_WIDTH;
  localparam int IN_TW = ((2 + 4 * IW + 7) / 8) * 8;

  typedef struct packed {
    logic signed [NUM_W-1:0] res_num;
    logic [DEN_W-1:0]        res_den;
    logic                    error;
  } frac_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TW-1:0] m_axis_tdata;
  logic m_axis_tuser;

  logic [IN_TW-1:0] pending_items[$];
  frac_res_t expected_fracs[$];
  int errors = 0;
  int n_results = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_cycles = 0;
  bit hold_done = 1'b0;
  bit stim_done = 1'b0;
  int n_in = 0;

  rational_arith_reduce_top #(.IN_WIDTH(IW)) u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic frac_res_t reduce_frac(logic [IN_TW-1:0] item);
    rar_op_t op;
    longint na, da, nb, db, n, d;
    longint unsigned g, nm, dm;
    frac_res_t r;
    op = rar_op_t'(item[1:0]);
    na = longint'($signed(item[2 +: IW]));
    da = longint'($signed(item[2 + IW +: IW]));
    nb = longint'($signed(item[2 + 2 * IW +: IW]));
    db = longint'($signed(item[2 + 3 * IW +: IW]));
    r.res_num = '0;
    r.res_den = DEN_W'(1);
    r.error = 1'b0;
    if (da == 0 || db == 0 || (op == OP_DIV && nb == 0)) begin
      r.error = 1'b1;
      return r;
    end
    case (op)
      OP_ADD: begin n = na * db + nb * da; d = da * db; end
      OP_SUB: begin n = na * db - nb * da; d = da * db; end
      OP_MUL: begin n = na * nb; d = da * db; end
      default: begin n = na * db; d = da * nb; end
    endcase
    if (n == 0) return r;
    nm = (n < 0) ? -n : n;
    dm = (d < 0) ? -d : d;
    g = gcd64(nm, dm);
    nm = nm / g;
    dm = dm / g;
    r.res_num = ((n < 0) != (d < 0)) ? NUM_W'(-$signed(nm)) : NUM_W'($signed(nm));
    r.res_den = dm[DEN_W-1:0];
    return r;
  endfunction

  function automatic logic [IN_TW-1:0] pack_item(rar_op_t op, logic [IW-1:0] na,
      logic [IW-1:0] da, logic [IW-1:0] nb, logic [IW-1:0] db);
    logic [IN_TW-1:0] v;
    v = '0;
    v[1:0] = op;
    v[2 +: IW] = na;
    v[2 + IW +: IW] = da;
    v[2 + 2 * IW +: IW] = nb;
    v[2 + 3 * IW +: IW] = db;
    return v;
  endfunction

  function automatic logic [IW-1:0] rand_field(int mode);
    case (mode)
      0: return IW'($urandom_range(0, 15) - 8);
      1: return $urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7fff;
      default: return IW'($urandom);
    endcase
  endfunction

  initial begin
    logic [IW-1:0] ext[6];
    rar_op_t op;
    ext = '{16'h8000, 16'h7fff, 16'h0001, 16'hffff, 16'h0000, 16'h8001};
    for (int o = 0; o < 4; o++) begin
      op = rar_op_t'(o);
      pending_items.push_back(pack_item(op, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
      pending_items.push_back(pack_item(op, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff));
      pending_items.push_back(pack_item(op, 16'h8000, 16'h0001, 16'h7fff, 16'hffff));
      pending_items.push_back(pack_item(op, 16'h0003, 16'h0000, 16'h0002, 16'h0005));
      pending_items.push_back(pack_item(op, 16'h0003, 16'h0004, 16'h0000, 16'hfffd));
    end
    pending_items.push_back(pack_item(OP_SUB, 16'h0002, 16'h0006, 16'h0001, 16'h0003));
    pending_items.push_back(pack_item(OP_ADD, 16'h0001, 16'h0002, 16'hffff, 16'h0002));
    pending_items.push_back(pack_item(OP_DIV, 16'hffff, 16'h0001, 16'h0001, 16'h8000));
    for (int i = 0; i < 1250; i++) begin
      int m;
      m = $urandom_range(0, 9);
      m = (m < 3) ? 0 : (m < 4) ? 1 : 2;
      for (int k = 0; k < 4; k++) ext[k] = rand_field(m);
      if ($urandom_range(0, 19) == 0) ext[$urandom_range(1, 3)] = '0;
      pending_items.push_back(pack_item(rar_op_t'($urandom_range(0, 3)),
                                        ext[0], ext[1], ext[2], ext[3]));
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // sender: bursts with gaps
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_fracs.push_back(reduce_frac(s_axis_tdata));
        n_in <= n_in + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          s_axis_tdata <= pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 300);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // receiver: stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (!hold_done && n_in >= 40) begin
        hold_cycles <= hold_cycles + 1;
        m_axis_tready <= 1'b0;
        if (hold_cycles == 2000) hold_done <= 1'b1;
      end else begin
        case ((n_in / 100) % 3)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    frac_res_t got, exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{res_num: m_axis_tdata[0 +: NUM_W], res_den: m_axis_tdata[NUM_W +: DEN_W],
              error: m_axis_tuser};
      n_results <= n_results + 1;
      if (expected_fracs.size() == 0) begin
        $error("result with nothing expected");
        errors <= errors + 1;
      end else begin
        exp_r = expected_fracs.pop_front();
        if (got.res_num !== exp_r.res_num) begin
          $error("res_num expected %0d got %0d", exp_r.res_num, got.res_num);
          errors <= errors + 1;
        end
        if (got.res_den !== exp_r.res_den) begin
          $error("res_den expected %0d got %0d", exp_r.res_den, got.res_den);
          errors <= errors + 1;
        end
        if (got.error !== exp_r.error) begin
          $error("error expected %0d got %0d", exp_r.error, got.error);
          errors <= errors + 1;
        end
      end
    end
  end

  initial begin
    @(negedge rst);
    wait (stim_done && !s_axis_tvalid && expected_fracs.size() == 0);
    repeat (300) @(posedge clk);
    $display("Covered %0d items over all four ops, extremes, zero cases and stalls.", n_in);
    $display("%0d results checked.", n_results);
    if (errors == 0 && expected_fracs.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl/core
rtl/core/rar_pkg.sv
rtl/core/rar_gcd.sv
rtl/core/rar_div.sv
rtl/core/rational_arith_reduce_top.sv
verif/rational_arith_reduce_top_tb.sv
